// ===== rtl/core/three_level_kmeans_classifier_core_defines.svh =====
// assertion macros used by the checker file
`ifndef THREE_LEVEL_KMEANS_CLASSIFIER_CORE_DEFINES_SVH
`define THREE_LEVEL_KMEANS_CLASSIFIER_CORE_DEFINES_SVH

// same-cycle implication
`define TLKC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlkc check failed");

// next-cycle implication
`define TLKC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlkc check failed");

`endif

// ===== rtl/core/tlkc_pkg.sv =====
package tlkc_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int MAX_PASSES  = 64;
    localparam int SAMPLE_BITS = 10;

    localparam int CFG_W    = 8;
    localparam int CENTRE_W = 12;
    localparam int ADDR_W   = $clog2(STORE_DEPTH);
    localparam int CNT_W    = $clog2(STORE_DEPTH + 1);
    localparam int SUM_W    = SAMPLE_BITS + ADDR_W;
    localparam int STEP_W   = $clog2(SUM_W);
    localparam int PASS_W   = $clog2(MAX_PASSES + 1);
    localparam int DIST_W   = ((SAMPLE_BITS + 1 > CENTRE_W) ? SAMPLE_BITS + 1 : CENTRE_W) + 1;

    localparam logic [CFG_W-1:0] SPREAD_RESET  = 8'd50;
    localparam logic [CFG_W-1:0] EVERY_RESET   = 8'd10;

    typedef enum logic [0:0] {
        REG_SPREAD = 1'b0,
        REG_EVERY  = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        CLASS_BLACK = 2'd0,
        CLASS_GREY  = 2'd1,
        CLASS_WHITE = 2'd2
    } class_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PASS_INIT,
        S_SCAN,
        S_DIV_LOAD,
        S_DIV_RUN,
        S_CHECK,
        S_OUT
    } state_t;

    function automatic class_t classify(
        input logic        [SAMPLE_BITS-1:0] v,
        input logic signed [CENTRE_W-1:0]    b,
        input logic signed [CENTRE_W-1:0]    g,
        input logic signed [CENTRE_W-1:0]    w
    );
        logic signed [DIST_W-1:0] vx;
        logic signed [DIST_W-1:0] eb;
        logic signed [DIST_W-1:0] eg;
        logic signed [DIST_W-1:0] ew;
        logic        [DIST_W-1:0] db;
        logic        [DIST_W-1:0] dg;
        logic        [DIST_W-1:0] dw;
        logic        [DIST_W-1:0] m;
        class_t                   c;
        vx = $signed({{(DIST_W-SAMPLE_BITS){1'b0}}, v});
        eb = vx - DIST_W'(b);
        eg = vx - DIST_W'(g);
        ew = vx - DIST_W'(w);
        db = (eb < 0) ? DIST_W'(-eb) : DIST_W'(eb);
        dg = (eg < 0) ? DIST_W'(-eg) : DIST_W'(eg);
        dw = (ew < 0) ? DIST_W'(-ew) : DIST_W'(ew);
        m  = (dg < dw) ? dg : dw;
        if (db < m)
        begin
            c = CLASS_BLACK;
        end
        else if (dg < dw)
        begin
            c = CLASS_GREY;
        end
        else
        begin
            c = CLASS_WHITE;
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/three_level_kmeans_classifier_core.sv =====
// a clustering run makes up to MAX_PASSES passes, each paced by the single store read port
// and the shared bit-serial divider
// one word at a time: in_ready is low from acceptance until the
// result is loaded
// asynchronous active-low reset clears control and centres and restores configuration defaults; store is not cleared
module three_level_kmeans_classifier_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [0:0]                         cfg_index,
    input  logic [tlkc_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [9:0]                         sample_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         sample_class,
    output logic signed [tlkc_pkg::CENTRE_W-1:0] black_centre,
    output logic signed [tlkc_pkg::CENTRE_W-1:0] grey_centre,
    output logic signed [tlkc_pkg::CENTRE_W-1:0] white_centre,
    output logic                               was_stored,
    output logic                               did_recluster,
    output logic                               pass_cap_hit
);
    import tlkc_pkg::*;

    state_t                      state_reg, state_next;
    logic [CFG_W-1:0]            spread_reg, spread_next;
    logic [CFG_W-1:0]            every_reg, every_next;
    logic                        calibrated_reg, calibrated_next;
    logic [CNT_W-1:0]            stored_count_reg, stored_count_next;
    logic [CFG_W-1:0]            since_reg, since_next;
    logic signed [CENTRE_W-1:0]  black_reg, black_next;
    logic signed [CENTRE_W-1:0]  grey_reg, grey_next;
    logic signed [CENTRE_W-1:0]  white_reg, white_next;
    logic signed [CENTRE_W-1:0]  old_black_reg, old_black_next;
    logic signed [CENTRE_W-1:0]  old_grey_reg, old_grey_next;
    logic signed [CENTRE_W-1:0]  old_white_reg, old_white_next;
    logic [SAMPLE_BITS-1:0]      sample_reg, sample_next;
    logic                        stored_reg, stored_next;
    logic                        recl_reg, recl_next;
    logic                        cap_reg, cap_next;
    logic [PASS_W-1:0]           pass_reg, pass_next;
    logic [CNT_W-1:0]            rd_addr_reg, rd_addr_next;
    logic                        rd_pend_reg, rd_pend_next;
    logic [SUM_W-1:0]            sum_reg [3];
    logic [SUM_W-1:0]            sum_next [3];
    logic [CNT_W-1:0]            cnt_reg [3];
    logic [CNT_W-1:0]            cnt_next [3];
    class_t                      div_sel_reg, div_sel_next;
    logic [CNT_W-1:0]            div_rem_reg, div_rem_next;
    logic [SUM_W-1:0]            div_quo_reg, div_quo_next;
    logic [STEP_W-1:0]           div_step_reg, div_step_next;
    logic                        out_valid_reg, out_valid_next;
    class_t                      out_class_reg, out_class_next;
    logic signed [CENTRE_W-1:0]  out_black_reg, out_black_next;
    logic signed [CENTRE_W-1:0]  out_grey_reg, out_grey_next;
    logic signed [CENTRE_W-1:0]  out_white_reg, out_white_next;
    logic                        out_stored_reg, out_stored_next;
    logic                        out_recl_reg, out_recl_next;
    logic                        out_cap_reg, out_cap_next;

    logic [SAMPLE_BITS-1:0]      store_mem [STORE_DEPTH];
    logic [SAMPLE_BITS-1:0]      mem_q_reg;
    logic                        store_we;
    logic [CNT_W-1:0]            rd_addr_use;

    logic [CFG_W:0]              every_eff;
    logic [CFG_W:0]              since_inc;
    class_t                      scan_class;
    class_t                      final_class;
    logic [CNT_W-1:0]            sel_cnt;
    logic [SUM_W-1:0]            sel_sum;
    logic [CNT_W:0]              div_trial;
    logic                        div_ge;
    logic [SUM_W-1:0]            div_quo_step;
    logic signed [CENTRE_W-1:0]  new_centre;

    assign in_ready = (state_reg == S_IDLE);

    assign every_eff = (every_reg == '0) ? (CFG_W+1)'(1 << CFG_W) : {1'b0, every_reg};
    assign since_inc = {1'b0, since_reg} + (CFG_W+1)'(1);

    assign scan_class  = classify(mem_q_reg, black_reg, grey_reg, white_reg);
    assign final_class = classify(sample_reg, black_reg, grey_reg, white_reg);

    always_comb
    begin
        unique case (div_sel_reg)
            CLASS_BLACK:
            begin
                sel_cnt = cnt_reg[0];
                sel_sum = sum_reg[0];
            end
            CLASS_GREY:
            begin
                sel_cnt = cnt_reg[1];
                sel_sum = sum_reg[1];
            end
            default:
            begin
                sel_cnt = cnt_reg[2];
                sel_sum = sum_reg[2];
            end
        endcase
    end

    // restoring divider, one quotient bit a cycle
    assign div_trial    = {div_rem_reg, div_quo_reg[SUM_W-1]};
    assign div_ge       = (div_trial >= {1'b0, sel_cnt});
    assign div_quo_step = {div_quo_reg[SUM_W-2:0], div_ge};
    assign new_centre   = CENTRE_W'(div_quo_step);

    assign store_we    = (state_reg == S_IDLE) && in_valid && calibrated_reg
                         && (stored_count_reg < CNT_W'(STORE_DEPTH));
    assign rd_addr_use = rd_addr_reg;

    always_comb
    begin
        state_next        = state_reg;
        spread_next       = spread_reg;
        every_next        = every_reg;
        calibrated_next   = calibrated_reg;
        stored_count_next = stored_count_reg;
        since_next        = since_reg;
        black_next        = black_reg;
        grey_next         = grey_reg;
        white_next        = white_reg;
        old_black_next    = old_black_reg;
        old_grey_next     = old_grey_reg;
        old_white_next    = old_white_reg;
        sample_next       = sample_reg;
        stored_next       = stored_reg;
        recl_next         = recl_reg;
        cap_next          = cap_reg;
        pass_next         = pass_reg;
        rd_addr_next      = rd_addr_reg;
        rd_pend_next      = rd_pend_reg;
        sum_next          = sum_reg;
        cnt_next          = cnt_reg;
        div_sel_next      = div_sel_reg;
        div_rem_next      = div_rem_reg;
        div_quo_next      = div_quo_reg;
        div_step_next     = div_step_reg;
        out_valid_next    = out_valid_reg;
        out_class_next    = out_class_reg;
        out_black_next    = out_black_reg;
        out_grey_next     = out_grey_reg;
        out_white_next    = out_white_reg;
        out_stored_next   = out_stored_reg;
        out_recl_next     = out_recl_reg;
        out_cap_next      = out_cap_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_SPREAD: spread_next = cfg_data;
                REG_EVERY:  every_next  = cfg_data;
                default:    spread_next = spread_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    sample_next = sample_value[SAMPLE_BITS-1:0];
                    stored_next = 1'b0;
                    recl_next   = 1'b0;
                    cap_next    = 1'b0;
                    pass_next   = '0;
                    state_next  = S_OUT;
                    if (!calibrated_reg)
                    begin
                        calibrated_next = 1'b1;
                        grey_next  = CENTRE_W'(sample_value[SAMPLE_BITS-1:0]);
                        white_next = CENTRE_W'(sample_value[SAMPLE_BITS-1:0])
                                     + CENTRE_W'(spread_reg);
                        black_next = CENTRE_W'(sample_value[SAMPLE_BITS-1:0])
                                     - CENTRE_W'(spread_reg);
                    end
                    else if (store_we)
                    begin
                        stored_count_next = stored_count_reg + CNT_W'(1);
                        stored_next       = 1'b1;
                        if (since_inc >= every_eff)
                        begin
                            since_next = '0;
                            recl_next  = 1'b1;
                            state_next = S_PASS_INIT;
                        end
                        else
                        begin
                            since_next = since_inc[CFG_W-1:0];
                        end
                    end
                end
            end
            S_PASS_INIT:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    sum_next[k] = '0;
                    cnt_next[k] = '0;
                end
                old_black_next = black_reg;
                old_grey_next  = grey_reg;
                old_white_next = white_reg;
                rd_addr_next   = '0;
                rd_pend_next   = 1'b0;
                pass_next      = pass_reg + PASS_W'(1);
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                if (rd_addr_reg < stored_count_reg)
                begin
                    rd_addr_next = rd_addr_reg + CNT_W'(1);
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    rd_pend_next = 1'b0;
                end
                if (rd_pend_reg)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        if (scan_class == class_t'(k))
                        begin
                            sum_next[k] = sum_reg[k] + SUM_W'(mem_q_reg);
                            cnt_next[k] = cnt_reg[k] + CNT_W'(1);
                        end
                    end
                end
                if ((rd_addr_reg == stored_count_reg) && !rd_pend_reg)
                begin
                    div_sel_next = CLASS_BLACK;
                    state_next   = S_DIV_LOAD;
                end
            end
            S_DIV_LOAD:
            begin
                div_rem_next  = '0;
                div_quo_next  = sel_sum;
                div_step_next = '0;
                if (sel_cnt != '0)
                begin
                    state_next = S_DIV_RUN;
                end
                else
                begin
                    unique case (div_sel_reg)
                        CLASS_BLACK: div_sel_next = CLASS_GREY;
                        CLASS_GREY:  div_sel_next = CLASS_WHITE;
                        default:     state_next   = S_CHECK;
                    endcase
                end
            end
            S_DIV_RUN:
            begin
                div_rem_next  = div_ge ? CNT_W'(div_trial - {1'b0, sel_cnt})
                                       : CNT_W'(div_trial);
                div_quo_next  = div_quo_step;
                div_step_next = div_step_reg + STEP_W'(1);
                if (div_step_reg == STEP_W'(SUM_W - 1))
                begin
                    state_next = S_DIV_LOAD;
                    unique case (div_sel_reg)
                        CLASS_BLACK:
                        begin
                            black_next   = new_centre;
                            div_sel_next = CLASS_GREY;
                        end
                        CLASS_GREY:
                        begin
                            grey_next    = new_centre;
                            div_sel_next = CLASS_WHITE;
                        end
                        default:
                        begin
                            white_next = new_centre;
                            state_next = S_CHECK;
                        end
                    endcase
                end
            end
            S_CHECK:
            begin
                if ((black_reg == old_black_reg) && (grey_reg == old_grey_reg)
                    && (white_reg == old_white_reg))
                begin
                    state_next = S_OUT;
                end
                else if (pass_reg == PASS_W'(MAX_PASSES))
                begin
                    cap_next   = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_PASS_INIT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_class_next  = final_class;
                    out_black_next  = black_reg;
                    out_grey_next   = grey_reg;
                    out_white_next  = white_reg;
                    out_stored_next = stored_reg;
                    out_recl_next   = recl_reg;
                    out_cap_next    = cap_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            spread_reg       <= SPREAD_RESET;
            every_reg        <= EVERY_RESET;
            calibrated_reg   <= 1'b0;
            stored_count_reg <= '0;
            since_reg        <= '0;
            black_reg        <= '0;
            grey_reg         <= '0;
            white_reg        <= '0;
            pass_reg         <= '0;
            rd_addr_reg      <= '0;
            rd_pend_reg      <= 1'b0;
            div_sel_reg      <= CLASS_BLACK;
            div_step_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            spread_reg       <= spread_next;
            every_reg        <= every_next;
            calibrated_reg   <= calibrated_next;
            stored_count_reg <= stored_count_next;
            since_reg        <= since_next;
            black_reg        <= black_next;
            grey_reg         <= grey_next;
            white_reg        <= white_next;
            pass_reg         <= pass_next;
            rd_addr_reg      <= rd_addr_next;
            rd_pend_reg      <= rd_pend_next;
            div_sel_reg      <= div_sel_next;
            div_step_reg     <= div_step_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        old_black_reg  <= old_black_next;
        old_grey_reg   <= old_grey_next;
        old_white_reg  <= old_white_next;
        sample_reg     <= sample_next;
        stored_reg     <= stored_next;
        recl_reg       <= recl_next;
        cap_reg        <= cap_next;
        sum_reg        <= sum_next;
        cnt_reg        <= cnt_next;
        div_rem_reg    <= div_rem_next;
        div_quo_reg    <= div_quo_next;
        out_class_reg  <= out_class_next;
        out_black_reg  <= out_black_next;
        out_grey_reg   <= out_grey_next;
        out_white_reg  <= out_white_next;
        out_stored_reg <= out_stored_next;
        out_recl_reg   <= out_recl_next;
        out_cap_reg    <= out_cap_next;
    end

    // sample store
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[stored_count_reg[ADDR_W-1:0]] <= sample_value[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        mem_q_reg <= store_mem[rd_addr_use[ADDR_W-1:0]];
    end

    assign out_valid     = out_valid_reg;
    assign sample_class  = out_class_reg;
    assign black_centre  = out_black_reg;
    assign grey_centre   = out_grey_reg;
    assign white_centre  = out_white_reg;
    assign was_stored    = out_stored_reg;
    assign did_recluster = out_recl_reg;
    assign pass_cap_hit  = out_cap_reg;

endmodule

// ===== rtl/core/tlkc_checker.sv =====
`include "three_level_kmeans_classifier_core_defines.svh"

module tlkc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] sample_class,
    input logic       was_stored,
    input logic       did_recluster,
    input logic       pass_cap_hit
);
    import tlkc_pkg::*;

    `TLKC_ASSERT_NEXT(a_out_held, out_valid && !out_ready, out_valid)
    `TLKC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    `TLKC_ASSERT_NOW(a_class_code, out_valid, sample_class <= CLASS_WHITE)
    `TLKC_ASSERT_NOW(a_recl_needs_store, out_valid && did_recluster, was_stored)
    `TLKC_ASSERT_NOW(a_cap_needs_recl, out_valid && pass_cap_hit, did_recluster)

endmodule

bind three_level_kmeans_classifier_core tlkc_checker u_tlkc_checker (.*);
